/* src/ira_pkg.sv */
// Package for the interval room allocator: sizes, the heap entry type,
// the entry ordering function and the sequencer states. No dependencies.
package ira_pkg;

	localparam int MAX_ROOMS = 256;
	localparam int TIME_BITS = 32;
	localparam int TAG_W     = 16;
	localparam int ROOM_W    = 9;
	localparam int IDX_W     = $clog2(MAX_ROOMS);
	localparam int CNT_W     = IDX_W + 1;

	typedef struct packed {
		logic [TIME_BITS-1:0] dep;
		logic [CNT_W-1:0]     room;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Result of the shared compare unit.
	typedef struct packed {
		logic pick_c;      // the second candidate beats the first
		logic best_first;  // the better candidate ranks before the moving entry
	} cmp_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOP_RD,
		ST_TOP_CHK,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_CMP
	} state_t;

	// Heap order: earlier departure first, then the higher room number.
	function automatic logic ranks_before(entry_t a, entry_t b);
		return (a.dep < b.dep) || ((a.dep == b.dep) && (a.room > b.room));
	endfunction

endpackage

/* src/ira_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// Self-contained; no package dependencies.
module ira_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* src/ira_cmp.sv */
// Shared compare unit for the heap sifts: picks the better of two stored
// entries and ranks it against the entry being moved. Uses ira_pkg.
module ira_cmp import ira_pkg::*; (
	input  entry_t   moving,
	input  entry_t   cand_b,
	input  entry_t   cand_c,
	input  logic     c_valid,
	output cmp_res_t res
);

	entry_t best;

	always_comb begin
		res.pick_c     = c_valid && ranks_before(cand_c, cand_b);
		best           = res.pick_c ? cand_c : cand_b;
		res.best_first = ranks_before(best, moving);
	end

endmodule

/* src/interval_room_allocator_core.sv */
// Top level of the interval room allocator: sequencer, heap bookkeeping and
// result registers. Uses ira_pkg, ira_ram and ira_cmp.
//
// Usage. A request is taken at a rising edge where start is high and busy is
// low; it carries first_of_set, arrival, departure and tag. Requests of one
// set must come sorted by arrival, then by departure. first_of_set empties the
// pool of occupied rooms and zeroes the room count before the request is
// handled. Each request gives exactly one result: done is high for exactly one
// cycle while tag_out, room, rooms_used and overflow hold the answer. The
// receiver cannot stall, so results must be taken as they come.
//
// Operation. The pool is a binary min-heap in one dual-read RAM, reached through
// a small sequencer and one shared compare unit. A request reads the root,
// then sifts the new or replaced entry through the heap one level at a time,
// at most log2(MAX_ROOMS) levels; an overflow skips the sift. busy stays high
// for the whole request, so a new request is taken only once the last is done.
//
// Reset clears the sequencer, the heap size and the room count; the heap RAM
// itself is not cleared, as entries beyond the heap size are never used.
// A new room requested while the heap is full raises overflow, reports room 0
// and leaves the heap untouched.
module interval_room_allocator_core import ira_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 first_of_set,
	input  logic [TIME_BITS-1:0] arrival,
	input  logic [TIME_BITS-1:0] departure,
	input  logic [TAG_W-1:0]     tag,
	output logic                 done,
	output logic [TAG_W-1:0]     tag_out,
	output logic [ROOM_W-1:0]    room,
	output logic [ROOM_W-1:0]    rooms_used,
	output logic                 overflow
);

	// Control state.
	state_t           state_q, state_d;
	logic [CNT_W-1:0] size_q, size_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             done_q, done_d;

	// Working registers for the request in flight.
	logic [TIME_BITS-1:0] arr_q;
	logic [TAG_W-1:0]     tag_q;
	entry_t               elem_q, elem_d;
	logic [IDX_W-1:0]     hole_q, hole_d;

	// Result registers.
	logic [TAG_W-1:0] tag_out_q;
	logic [CNT_W-1:0] room_q, room_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic             ovf_q, ovf_d;
	logic             res_ld;

	// RAM ports.
	logic             we;
	logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
	entry_t           wdata, rdata_a, rdata_b;

	// Heap index arithmetic: parent of the hole, and its two children.
	logic [IDX_W-1:0] parent_idx;
	logic [CNT_W:0]   left_idx, right_idx;
	logic             right_valid;

	cmp_res_t cmp_res;
	logic     accept;
	logic     new_room;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign parent_idx  = (hole_q - 1'b1) >> 1;
	assign left_idx    = {1'b0, hole_q, 1'b1};
	assign right_idx   = left_idx + 1'b1;
	assign right_valid = right_idx < {1'b0, size_q};

	// A new room is opened when the pool is empty or its earliest departure
	// is not strictly before the arrival of this request.
	assign new_room = (size_q == '0) || (rdata_a.dep >= arr_q);

	ira_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ROOMS)
	) u_heap (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	// During a sift up only port A carries the parent; during a sift down
	// port A holds the left child and port B the right one.
	ira_cmp u_cmp (
		.moving  (elem_q),
		.cand_b  (rdata_a),
		.cand_c  (rdata_b),
		.c_valid ((state_q == ST_DN_CMP) && right_valid),
		.res     (cmp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			size_q  <= size_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			arr_q <= arrival;
			tag_q <= tag;
		end
		elem_q <= elem_d;
		hole_q <= hole_d;
		if (res_ld) begin
			tag_out_q <= tag_q;
			room_q    <= room_d;
			used_q    <= used_d;
			ovf_q     <= ovf_d;
		end
	end

	// Sequencer: next state, heap bookkeeping and RAM control.
	always_comb begin
		state_d = state_q;
		size_d  = size_q;
		count_d = count_q;
		done_d  = 1'b0;
		elem_d  = elem_q;
		hole_d  = hole_q;
		res_ld  = 1'b0;
		room_d  = room_q;
		used_d  = used_q;
		ovf_d   = ovf_q;
		we      = 1'b0;
		waddr   = hole_q;
		wdata   = elem_q;
		raddr_a = '0;
		raddr_b = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					elem_d.dep = departure;
					if (first_of_set) begin
						size_d  = '0;
						count_d = '0;
					end
					state_d = ST_TOP_RD;
				end
			end
			ST_TOP_RD: begin
				raddr_a = '0;
				state_d = ST_TOP_CHK;
			end
			ST_TOP_CHK: begin
				res_ld = 1'b1;
				if (new_room) begin
					if (size_q == CNT_W'(MAX_ROOMS)) begin
						room_d  = '0;
						used_d  = count_q;
						ovf_d   = 1'b1;
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						count_d     = count_q + 1'b1;
						size_d      = size_q + 1'b1;
						elem_d.room = count_q + 1'b1;
						hole_d      = size_q[IDX_W-1:0];
						room_d      = count_q + 1'b1;
						used_d      = count_q + 1'b1;
						ovf_d       = 1'b0;
						state_d     = ST_UP_RD;
					end
				end else begin
					// Reuse the top room; the root becomes the hole.
					elem_d.room = rdata_a.room;
					hole_d      = '0;
					room_d      = rdata_a.room;
					used_d      = count_q;
					ovf_d       = 1'b0;
					state_d     = ST_DN_RD;
				end
			end
			ST_UP_RD: begin
				if (hole_q == '0) begin
					we      = 1'b1;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					raddr_a = parent_idx;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				we = 1'b1;
				if (cmp_res.best_first) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					wdata   = rdata_a;
					hole_d  = parent_idx;
					state_d = ST_UP_RD;
				end
			end
			ST_DN_RD: begin
				if (left_idx >= {1'b0, size_q}) begin
					we      = 1'b1;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					raddr_a = left_idx[IDX_W-1:0];
					raddr_b = right_idx[IDX_W-1:0];
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				we = 1'b1;
				if (cmp_res.best_first) begin
					wdata   = cmp_res.pick_c ? rdata_b : rdata_a;
					hole_d  = cmp_res.pick_c ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
					state_d = ST_DN_RD;
				end else begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign done       = done_q;
	assign tag_out    = tag_out_q;
	assign room       = ROOM_W'(room_q);
	assign rooms_used = ROOM_W'(used_q);
	assign overflow   = ovf_q;

	// Every opened room has exactly one heap entry.
	a_size_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		size_q == count_q)
		else $error("heap size and room count disagree");

	a_size_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= CNT_W'(MAX_ROOMS))
		else $error("heap size beyond capacity");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_ovf_no_room: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ovf_q) |-> (room_q == '0))
		else $error("overflow result carries a room");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && !done_q))
		else $error("accepted request did not start work");

endmodule

/* tb/room_allocation_checker.sv */
`timescale 1ns / 1ps
// Checker for the interval room allocator: watches the request and result
// channels, predicts each allocation and compares it. Depends on ira_pkg.
module room_allocation_checker import ira_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 first_of_set,
	input  logic [TIME_BITS-1:0] arrival,
	input  logic [TIME_BITS-1:0] departure,
	input  logic [TAG_W-1:0]     tag,
	input  logic                 done,
	input  logic [TAG_W-1:0]     tag_out,
	input  logic [ROOM_W-1:0]    room,
	input  logic [ROOM_W-1:0]    rooms_used,
	input  logic                 overflow,
	output int                   fail_count,
	output int                   pending
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [ROOM_W-1:0] room;
		logic [ROOM_W-1:0] rooms_used;
		logic              overflow;
	} allocation_t;

	// Occupied rooms of the current set, kept unordered; the earliest
	// departure is found by a full scan rather than a heap.
	entry_t            occupied [MAX_ROOMS];
	int                occupied_count;
	logic [ROOM_W-1:0] rooms_opened;
	allocation_t       awaited [$];
	allocation_t       oldest;
	int                mismatches;

	function automatic allocation_t allocate_room(logic fs, logic [TIME_BITS-1:0] arr,
			logic [TIME_BITS-1:0] dep, logic [TAG_W-1:0] tg);
		allocation_t a;
		int          earliest;
		int          i;
		if (fs) begin
			occupied_count = 0;
			rooms_opened   = '0;
		end
		a.tag      = tg;
		a.room     = '0;
		a.overflow = 1'b0;
		earliest   = 0;
		for (i = 1; i < occupied_count; i++) begin
			if (occupied[i].dep < occupied[earliest].dep ||
					(occupied[i].dep == occupied[earliest].dep &&
					 occupied[i].room > occupied[earliest].room))
				earliest = i;
		end
		if (occupied_count == 0 || occupied[earliest].dep >= arr) begin
			if (occupied_count >= MAX_ROOMS) begin
				a.overflow = 1'b1;
			end else begin
				rooms_opened++;
				occupied[occupied_count].dep  = dep;
				occupied[occupied_count].room = rooms_opened;
				occupied_count++;
				a.room = rooms_opened;
			end
		end else begin
			a.room                  = occupied[earliest].room;
			occupied[earliest].dep = dep;
		end
		a.rooms_used = rooms_opened;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_count = 0;
			rooms_opened   = '0;
			mismatches     = 0;
			awaited.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// Results are compared before the request of this edge is added,
			// as a result can only answer an earlier request.
			if (done) begin
				if (awaited.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: result tag %h room %0d used %0d ovf %0b with no request outstanding",
							$time, tag_out, room, rooms_used, overflow);
					mismatches++;
				end else begin
					oldest = awaited.pop_front();
					if (tag_out !== oldest.tag || room !== oldest.room ||
							rooms_used !== oldest.rooms_used || overflow !== oldest.overflow) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: expected tag %h room %0d used %0d ovf %0b, got tag %h room %0d used %0d ovf %0b",
								$time, oldest.tag, oldest.room, oldest.rooms_used, oldest.overflow,
								tag_out, room, rooms_used, overflow);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				awaited.push_back(allocate_room(first_of_set, arrival, departure, tag));
			fail_count <= mismatches;
			pending    <= awaited.size();
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the interval room allocator testbench: clock, reset, request stimulus
// and the verdict. Depends on ira_pkg, the allocator RTL and room_allocation_checker.
module tb_top;
	import ira_pkg::*;

	// The cycle limit leaves a wide margin over the whole run, even with
	// long idle stretches.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int REQUEST_GOAL  = 560;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 first_of_set;
	logic [TIME_BITS-1:0] arrival;
	logic [TIME_BITS-1:0] departure;
	logic [TAG_W-1:0]     tag;
	logic                 done;
	logic [TAG_W-1:0]     tag_out;
	logic [ROOM_W-1:0]    room;
	logic [ROOM_W-1:0]    rooms_used;
	logic                 overflow;

	int fail_count;
	int pending_results;
	int cycle_count   = 0;
	int requests_sent = 0;
	int idle_pct      = 0;
	int i;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	interval_room_allocator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_of_set (first_of_set),
		.arrival      (arrival),
		.departure    (departure),
		.tag          (tag),
		.done         (done),
		.tag_out      (tag_out),
		.room         (room),
		.rooms_used   (rooms_used),
		.overflow     (overflow)
	);

	room_allocation_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_of_set (first_of_set),
		.arrival      (arrival),
		.departure    (departure),
		.tag          (tag),
		.done         (done),
		.tag_out      (tag_out),
		.room         (room),
		.rooms_used   (rooms_used),
		.overflow     (overflow),
		.fail_count   (fail_count),
		.pending      (pending_results)
	);

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Adds two times, saturating at the top of the time range so that a set
	// near the end of the range stays sorted.
	function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a,
			logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
	endfunction

	// Presents one request from a falling edge and holds it until a rising
	// edge finds busy low. The sender's idle rate cycles through phases of no
	// idling, heavy idling and light idling; the receiver cannot stall, so
	// only the sender side has anything to vary. Each falling edge carries a
	// single assignment to start, so a back-to-back request keeps it high.
	task automatic book(input logic fs, input logic [TIME_BITS-1:0] arr,
			input logic [TIME_BITS-1:0] dep, input logic [TAG_W-1:0] tg);
		case ((requests_sent / 48) % 3)
			0:       idle_pct = 0;
			1:       idle_pct = 84;
			default: idle_pct = 31;
		endcase
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start        <= 1'b1;
		first_of_set <= fs;
		arrival      <= arr;
		departure    <= dep;
		tag          <= tg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	// Holds the sender back until every request has been answered. The last
	// request is withdrawn first so that it is not taken a second time.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results != 0)
			@(posedge clk);
	endtask

	// One well-formed set: arrivals nondecreasing, departures nondecreasing
	// among equal arrivals. Narrow steps and durations give many departure
	// ties, which exercise the higher-room-first rule. A few requests inside
	// the set are replaced by random ones, which breaks the ordering.
	task automatic booking_set(input bit fresh);
		int                   n;
		int                   step_max;
		int                   dur_max;
		int                   k;
		logic [TIME_BITS-1:0] t;
		logic [TIME_BITS-1:0] d;
		logic [TIME_BITS-1:0] prev_arr;
		logic [TIME_BITS-1:0] prev_dep;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
		case ($urandom_range(0, 3))
			0:       t = $urandom;
			1:       t = '1 - $urandom_range(0, 300);
			2:       t = $urandom_range(0, 50);
			default: t = $urandom & 32'h00FF_FFFF;
		endcase
		case ($urandom_range(0, 2))
			0:       step_max = 3;
			1:       step_max = 20;
			default: step_max = 1000;
		endcase
		case ($urandom_range(0, 3))
			0:       dur_max = 3;
			1:       dur_max = 40;
			2:       dur_max = 5000;
			default: dur_max = 1000000;
		endcase
		prev_arr = '0;
		prev_dep = '0;
		for (k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(0, 24) == 0) begin
				book(1'b0, $urandom, $urandom, TAG_W'($urandom_range(0, 65535)));
			end else begin
				t = sat_add(t, $urandom_range(0, step_max));
				d = sat_add(t, $urandom_range(0, dur_max));
				if (k > 0 && t == prev_arr && d < prev_dep)
					d = prev_dep;
				book(fresh && k == 0, t, d, TAG_W'($urandom_range(0, 65535)));
				prev_arr = t;
				prev_dep = d;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		first_of_set = 1'b0;
		arrival      = '0;
		departure    = '0;
		tag          = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests. The first set starts at time zero and works
		// through the tie between equal departures, reuse when the earliest
		// departure is strictly before the arrival, and a new room when it
		// equals the arrival.
		book(1'b1, 32'd0, 32'd0, 16'h0000);
		book(1'b0, 32'd0, 32'd0, 16'hFFFF);
		book(1'b0, 32'd1, 32'd5, 16'h0001);
		book(1'b0, 32'd1, 32'd5, 16'h0002);
		book(1'b0, 32'd5, 32'd5, 16'h0003);
		book(1'b0, 32'd6, 32'd9, 16'h0004);
		// A set at the very top of the time range, with a departure before
		// its arrival and then an arrival that goes backwards.
		book(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hABCD);
		book(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 16'h1234);
		book(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
		book(1'b0, 32'h0000_0000, 32'h0000_0007, 16'h7FFF);
		// Alternating and complementary bit patterns on the time and tag fields.
		book(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h5555);
		book(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
		book(1'b0, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 16'h00FF);
		book(1'b0, 32'hAAAA_AAAB, 32'hAAAA_AAAB, 16'hFF00);

		// Let every outstanding request be answered before the long set below.
		wait_drained();

		// Fill every room with overlapping bookings, then ask for two more to
		// hit the full pool. Departures fall in a narrow band so that ties
		// appear across a deep heap. The bookings after that arrive once all
		// departures have passed and reuse rooms through full-depth sifts.
		for (i = 0; i < MAX_ROOMS + 2; i++)
			book(i == 0, 32'd1000 + i, 32'd4_000_000 + $urandom_range(0, 63),
				TAG_W'($urandom_range(0, 65535)));
		for (i = 0; i < 8; i++)
			book(1'b0, 32'd4_000_100 + i, 32'd4_000_100 + i + $urandom_range(0, 63),
				TAG_W'($urandom_range(0, 65535)));

		// Random part: mostly sorted sets with random content, some of them
		// running on from the previous set, plus short bursts of noise.
		while (requests_sent < REQUEST_GOAL) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					book($urandom_range(0, 7) == 0, $urandom, $urandom,
						TAG_W'($urandom_range(0, 65535)));
			end else begin
				booking_set($urandom_range(0, 9) != 0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
